@@ rtl/core/apq_pkg.sv @@
// shared types, constants and microcode table for the array priority queue
package apq_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned UPC_W = 4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] data;
  } entry_t;

  typedef enum logic [3:0] {
    OP_FETCH,
    OP_NOP,
    OP_INSERT,
    OP_RD_FIRST,
    OP_LOAD_BEST,
    OP_SCAN,
    OP_EMIT_REM,
    OP_SHIFT,
    OP_DEC,
    OP_EMIT_FULL,
    OP_EMIT_EMPTY
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_REMOVE,
    C_FULL,
    C_EMPTY,
    C_SINGLE,
    C_SCAN_MORE,
    C_NO_SHIFT,
    C_SHIFT_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic remove;
    logic full;
    logic empty;
    logic single;
    logic scan_more;
    logic no_shift;
    logic shift_more;
  } flags_t;

  // program addresses
  localparam logic [UPC_W-1:0] U_FETCH   = 4'd0;
  localparam logic [UPC_W-1:0] U_DECODE  = 4'd1;
  localparam logic [UPC_W-1:0] U_INS_CHK = 4'd2;
  localparam logic [UPC_W-1:0] U_INS_WR  = 4'd3;
  localparam logic [UPC_W-1:0] U_REM     = 4'd4;
  localparam logic [UPC_W-1:0] U_LOAD    = 4'd5;
  localparam logic [UPC_W-1:0] U_SCAN    = 4'd6;
  localparam logic [UPC_W-1:0] U_EMIT    = 4'd7;
  localparam logic [UPC_W-1:0] U_SHIFT   = 4'd8;
  localparam logic [UPC_W-1:0] U_DEC     = 4'd9;
  localparam logic [UPC_W-1:0] U_FULL    = 4'd10;
  localparam logic [UPC_W-1:0] U_EMPTY   = 4'd11;

  function automatic ctrl_t ucode(logic [UPC_W-1:0] addr);
    ctrl_t w;
    case (addr)
      U_FETCH:   w = '{op: OP_FETCH,      cond: C_NO_ITEM,    target: U_FETCH};
      U_DECODE:  w = '{op: OP_NOP,        cond: C_REMOVE,     target: U_REM};
      U_INS_CHK: w = '{op: OP_NOP,        cond: C_FULL,       target: U_FULL};
      U_INS_WR:  w = '{op: OP_INSERT,     cond: C_ALWAYS,     target: U_FETCH};
      U_REM:     w = '{op: OP_RD_FIRST,   cond: C_EMPTY,      target: U_EMPTY};
      U_LOAD:    w = '{op: OP_LOAD_BEST,  cond: C_SINGLE,     target: U_EMIT};
      U_SCAN:    w = '{op: OP_SCAN,       cond: C_SCAN_MORE,  target: U_SCAN};
      U_EMIT:    w = '{op: OP_EMIT_REM,   cond: C_NO_SHIFT,   target: U_DEC};
      U_SHIFT:   w = '{op: OP_SHIFT,      cond: C_SHIFT_MORE, target: U_SHIFT};
      U_DEC:     w = '{op: OP_DEC,        cond: C_ALWAYS,     target: U_FETCH};
      U_FULL:    w = '{op: OP_EMIT_FULL,  cond: C_ALWAYS,     target: U_FETCH};
      U_EMPTY:   w = '{op: OP_EMIT_EMPTY, cond: C_ALWAYS,     target: U_FETCH};
      default:   w = '{op: OP_NOP,        cond: C_ALWAYS,     target: U_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/apq_if.sv @@
// request and response channel interfaces
interface apq_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  priority_req;
  logic [15:0] payload;

  modport source (output valid, output command, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input command, input priority_req, input payload,
                  output ready);
endinterface

interface apq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_priority;
  logic [15:0] out_payload;

  modport source (output valid, output status, output out_priority, output out_payload,
                  input ready);
  modport sink   (input valid, input status, input out_priority, input out_payload,
                  output ready);
endinterface

@@ rtl/core/array_priority_queue.sv @@
// Priority queue of up to DEPTH (8) entries kept unsorted in a small memory. One item is
// handled at a time, under control of a microprogram. An insert is decoded, checked for a
// full store and written before the next item can be accepted. A remove of n stored
// entries reads entry 0, scans the others from newest to oldest keeping the strict minimum
// (the oldest entry wins a tie with it, otherwise the newest of the minima), then shifts
// later entries down one place each cycle; the entries are read one at a time through the
// single read port of the entry memory. Full and empty requests are reported without
// changing the store. The result waits in an output register; a new item is accepted once
// the previous result has been taken or is taken in the same cycle.
module array_priority_queue import apq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  apq_req_if.sink  req_i,
  apq_rsp_if.source rsp_o
);

  op_e    op;
  flags_t flags;

  apq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  apq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .flags_o        (flags),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .command_i      (req_i.command),
    .priority_req_i (req_i.priority_req),
    .payload_i      (req_i.payload),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .out_priority_o (rsp_o.out_priority),
    .out_payload_o  (rsp_o.out_payload)
  );

`ifndef SYNTHESIS
  // never take an item while an untaken result would be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!rsp_o.valid || rsp_o.ready))
    else $error("item accepted while result pending");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("ready right after accept");

  // only a removal carries entry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_REMOVED) |->
      (rsp_o.out_priority == 8'd0 && rsp_o.out_payload == 16'd0))
    else $error("nonzero data on non-remove result");

  // the store never passes full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags.full |-> op != OP_INSERT)
    else $error("insert into full store");
`endif

endmodule

@@ rtl/core/apq_seq.sv @@
// microprogram sequencer: step counter, control rom and jump logic
module apq_seq import apq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output op_e    op_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            cw;
  logic             take;

  assign cw   = ucode(upc_q);
  assign op_o = cw.op;

  always_comb begin
    case (cw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ITEM:    take = !flags_i.in_fire;
      C_REMOVE:     take = flags_i.remove;
      C_FULL:       take = flags_i.full;
      C_EMPTY:      take = flags_i.empty;
      C_SINGLE:     take = flags_i.single;
      C_SCAN_MORE:  take = flags_i.scan_more;
      C_NO_SHIFT:   take = flags_i.no_shift;
      C_SHIFT_MORE: take = flags_i.shift_more;
      default:      take = 1'b1;
    endcase
    upc_d = take ? cw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ rtl/core/apq_dp.sv @@
// datapath: entry store, scan and shift registers, item latch and result register
module apq_dp import apq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_e         op_i,
  output flags_t      flags_o,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_payload_o
);

  entry_t mem [DEPTH];

  logic          cmd_q;
  entry_t        new_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  entry_t        rd_data_q;
  logic [AW-1:0] best_addr_q;
  entry_t        best_q;
  logic          out_valid_q;
  logic [1:0]    status_q;
  entry_t        out_q;
  logic          in_fire;
  logic [AW-1:0] last_addr;

  assign in_ready_o = (op_i == OP_FETCH) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_addr  = AW'(count_q - CW'(1));

  assign flags_o.in_fire    = in_fire;
  assign flags_o.remove     = (cmd_q == CMD_REMOVE);
  assign flags_o.full       = (count_q == CW'(DEPTH));
  assign flags_o.empty      = (count_q == '0);
  assign flags_o.single     = (count_q == CW'(1));
  assign flags_o.scan_more  = (rd_addr_q != AW'(1));
  assign flags_o.no_shift   = ((CW'(best_addr_q) + CW'(1)) == count_q);
  assign flags_o.shift_more = ((CW'(rd_addr_q) + CW'(1)) < count_q);

  always_comb begin
    case (op_i)
      OP_RD_FIRST:  rd_addr_d = '0;
      OP_LOAD_BEST: rd_addr_d = last_addr;
      OP_SCAN:      rd_addr_d = rd_addr_q - AW'(1);
      OP_EMIT_REM:  rd_addr_d = best_addr_q + AW'(1);
      OP_SHIFT:     rd_addr_d = rd_addr_q + AW'(1);
      default:      rd_addr_d = rd_addr_q;
    endcase
  end

  // entry store, registered read
  always_ff @(posedge clk_i) begin
    if (op_i == OP_INSERT) begin
      mem[count_q[AW-1:0]] <= new_q;
    end else if (op_i == OP_SHIFT) begin
      mem[rd_addr_q - AW'(1)] <= rd_data_q;
    end
    rd_data_q <= mem[rd_addr_d];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    if (in_fire) begin
      cmd_q      <= command_i;
      new_q.prio <= priority_req_i;
      new_q.data <= payload_i;
    end
    if (op_i == OP_LOAD_BEST) begin
      best_q      <= rd_data_q;
      best_addr_q <= '0;
    end else if (op_i == OP_SCAN && rd_data_q.prio < best_q.prio) begin
      best_q      <= rd_data_q;
      best_addr_q <= rd_addr_q;
    end
    case (op_i)
      OP_INSERT: begin
        status_q <= ST_INSERTED;
        out_q    <= '0;
      end
      OP_EMIT_REM: begin
        status_q <= ST_REMOVED;
        out_q    <= best_q;
      end
      OP_EMIT_FULL: begin
        status_q <= ST_FULL;
        out_q    <= '0;
      end
      OP_EMIT_EMPTY: begin
        status_q <= ST_EMPTY;
        out_q    <= '0;
      end
      default: begin
        status_q <= status_q;
        out_q    <= out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_INSERT) begin
        count_q <= count_q + CW'(1);
      end else if (op_i == OP_DEC) begin
        count_q <= count_q - CW'(1);
      end
      if (op_i == OP_INSERT || op_i == OP_EMIT_REM || op_i == OP_EMIT_FULL ||
          op_i == OP_EMIT_EMPTY) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = out_q.prio;
  assign out_payload_o  = out_q.data;

endmodule

@@ sim/array_priority_queue_tb.sv @@
// self-checking testbench for the array priority queue
`timescale 1ns / 100ps

module array_priority_queue_tb;
  import apq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RAND_PER_PHASE = 300;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic        command;
    logic [7:0]  prio;
    logic [15:0] data;
  } queue_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [15:0] data;
  } queue_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  apq_req_if req_if ();
  apq_rsp_if rsp_if ();

  array_priority_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the queue contents
  entry_t      mirror_entries [DEPTH];
  int unsigned mirror_count = 0;

  queue_op_t   queued_ops [$];
  queue_rsp_t  pending_results [$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        rsp_hold = 1'b0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  function automatic queue_rsp_t serve_queue_op(queue_op_t op);
    queue_rsp_t  r;
    int unsigned best;
    logic [7:0]  best_prio;
    r = '{status: ST_INSERTED, prio: 8'd0, data: 16'd0};
    if (op.command == CMD_INSERT) begin
      if (mirror_count < DEPTH) begin
        mirror_entries[mirror_count] = '{prio: op.prio, data: op.data};
        mirror_count++;
      end else begin
        r.status = ST_FULL;
      end
    end else if (mirror_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // entry 0 is the first candidate, then newest to oldest on strict less-than
      best      = 0;
      best_prio = mirror_entries[0].prio;
      for (int i = int'(mirror_count) - 1; i > 0; i--) begin
        if (mirror_entries[i].prio < best_prio) begin
          best_prio = mirror_entries[i].prio;
          best      = i;
        end
      end
      r.status = ST_REMOVED;
      r.prio   = best_prio;
      r.data   = mirror_entries[best].data;
      for (int unsigned i = best; i + 1 < mirror_count; i++)
        mirror_entries[i] = mirror_entries[i + 1];
      mirror_count--;
    end
    return r;
  endfunction

  // driver: offers items from queued_ops, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin : driver
    queue_op_t nxt;
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_INSERT;
      req_if.priority_req <= 8'd0;
      req_if.payload      <= 16'd0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        nxt = '{command: req_if.command, prio: req_if.priority_req, data: req_if.payload};
        pending_results.push_back(serve_queue_op(nxt));
      end
      if (!req_if.valid || req_if.ready) begin
        if (queued_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = queued_ops.pop_front();
          req_if.valid        <= 1'b1;
          req_if.command      <= nxt.command;
          req_if.priority_req <= nxt.prio;
          req_if.payload      <= nxt.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compares each taken result with the oldest prediction
  always @(posedge clk_i) begin : monitor
    queue_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: status=%0d prio=%0d data=%h",
                   rsp_if.status, rsp_if.out_priority, rsp_if.out_payload);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.out_priority !== want.prio ||
            rsp_if.out_payload !== want.data) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp status=%0d prio=%0d data=%h, got status=%0d prio=%0d data=%h",
                     want.status, want.prio, want.data,
                     rsp_if.status, rsp_if.out_priority, rsp_if.out_payload);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_req);
    @(negedge clk_i);
    rsp_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rsp_hold = 1'b0;
  end

  task automatic push_op(logic cmd, logic [7:0] prio, logic [15:0] data);
    queued_ops.push_back('{command: cmd, prio: prio, data: data});
  endtask

  // bursts with a varying insert bias so the store swings between empty and full
  task automatic push_random(int unsigned n);
    int unsigned ins_pct;
    logic [7:0]  prio;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 24 == 0) begin
        case ($urandom_range(2))
          0:       ins_pct = 25;
          1:       ins_pct = 50;
          default: ins_pct = 75;
        endcase
      end
      // narrow priorities give plenty of ties
      prio = ($urandom_range(1) != 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      push_op(($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE, prio,
              16'($urandom_range(65535)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (queued_ops.size() != 0 || req_if.valid || pending_results.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct   = 23;
    recv_stall_pct = 50;

    push_op(CMD_REMOVE, 8'd0, 16'd0);           // empty queue
    push_op(CMD_INSERT, 8'd5, 16'h0001);
    push_op(CMD_INSERT, 8'd255, 16'hffff);
    push_op(CMD_INSERT, 8'd5, 16'h0003);        // ties with the oldest entry
    push_op(CMD_INSERT, 8'd0, 16'h0000);
    push_op(CMD_INSERT, 8'd0, 16'haaaa);
    push_op(CMD_INSERT, 8'd128, 16'h5555);
    push_op(CMD_INSERT, 8'd0, 16'h1234);        // newest of the minima
    push_op(CMD_INSERT, 8'd255, 16'h0000);
    push_op(CMD_INSERT, 8'd1, 16'hbeef);        // full, dropped
    for (int k = 0; k < DEPTH; k++)
      push_op(CMD_REMOVE, 8'hff, 16'hffff);
    push_op(CMD_REMOVE, 8'd0, 16'd0);           // empty again
    wait_drained();

    push_random(RAND_PER_PHASE);
    wait_drained();

    send_gap_pct   = 50;
    recv_stall_pct = 23;
    push_random(RAND_PER_PHASE);
    wait_drained();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    push_random(RAND_PER_PHASE);
    hold_req = 1'b1;
    wait_drained();

    repeat (40) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
